// ----- rtl/core/pftm_pkg.sv -----
// shared constants, configuration and pipeline stage types for the floor texel mapper
package pftm_pkg;

  localparam int SCREEN_WIDTH  = 320;
  localparam int SCREEN_HEIGHT = 240;
  localparam int MAP_DIM_MAX   = 4096;
  localparam int DEPTH_OFFSET  = 300;
  localparam int Q14_FRAC      = 14;

  localparam int COL_W  = 9;
  localparam int ROW_W  = 8;
  localparam int Y_W    = 10;
  localparam int DEN_W  = 8;
  localparam int PROD_W = 26;
  localparam int NUM_W  = 42;
  localparam int QUOT_W = 27;
  localparam int POS_W  = 29;
  localparam int HI_W   = 20;
  localparam int MAP_W  = 13;
  localparam int DIM_W  = $clog2(MAP_DIM_MAX);

  localparam logic signed [COL_W:0] X_CENTER = (COL_W + 1)'(SCREEN_WIDTH / 2);
  localparam logic signed [ROW_W:0] Z_CENTER = (ROW_W + 1)'(SCREEN_HEIGHT / 2);
  localparam logic [Y_W-1:0]        Y_OFFSET = Y_W'(DEPTH_OFFSET);
  localparam logic [MAP_W-1:0]      DIM_HI   = MAP_W'(MAP_DIM_MAX);

  typedef enum logic [2:0] {
    REG_SINE       = 3'd0,
    REG_COSINE     = 3'd1,
    REG_ZOOM       = 3'd2,
    REG_CAMERA_X   = 3'd3,
    REG_CAMERA_Z   = 3'd4,
    REG_WRAP_MODE  = 3'd5,
    REG_MAP_WIDTH  = 3'd6,
    REG_MAP_HEIGHT = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic signed [15:0] sine;
    logic signed [15:0] cosine;
    logic [15:0]        zoom;
    logic signed [23:0] cam_x;
    logic signed [23:0] cam_z;
    logic               wrap;
    logic [DIM_W-1:0]   w_m1;
    logic [DIM_W-1:0]   h_m1;
  } cfg_t;

  // folded numerators ready for the unsigned divide
  typedef struct packed {
    logic              vld;
    logic [QUOT_W-1:0] ux;
    logic [QUOT_W-1:0] uy;
    logic              sx;
    logic              sy;
    logic [DEN_W-1:0]  den;
  } front_t;

  typedef struct packed {
    logic              vld;
    logic [QUOT_W-1:0] ux;
    logic [QUOT_W-1:0] uy;
    logic              sx;
    logic              sy;
    logic [DEN_W-1:0]  den;
    logic [DEN_W-1:0]  rem_x;
    logic [DEN_W-1:0]  rem_y;
    logic [QUOT_W-1:0] qx;
    logic [QUOT_W-1:0] qy;
  } div_stage_t;

  typedef struct packed {
    logic              vld;
    logic [QUOT_W-1:0] qx;
    logic [QUOT_W-1:0] qy;
    logic              sx;
    logic              sy;
  } quot_t;

  typedef struct packed {
    logic             vld;
    logic [HI_W-1:0]  hix;
    logic [HI_W-1:0]  hiy;
    logic [DIM_W-1:0] rem_x;
    logic [DIM_W-1:0] rem_y;
    logic             lo_x;
    logic             lo_y;
    logic [DIM_W-1:0] cx;
    logic [DIM_W-1:0] cy;
    logic             outside;
  } mod_stage_t;

  typedef struct packed {
    logic [DIM_W-1:0] texel_x;
    logic [DIM_W-1:0] texel_y;
    logic             outside;
  } res_t;

endpackage

// ----- rtl/core/perspective_floor_texel_mapper_top.sv -----
// top level of the perspective floor texel mapper
// Maps a lower-half screen pixel to the floor texture coordinate it shows.
// Input channel: in_valid/in_ready carry one request with in_pixel_col and
// in_pixel_row. Result channel: out_valid/out_ready carry out_texel_x,
// out_texel_y and out_outside, one result per request, in request order.
// Configuration: cfg_we writes cfg_wdata into register cfg_index;
// write only while no request is in flight.
// Throughput: one request per cycle unless the receiver stalls; the pipeline
// is 5 front stages, a 27-stage quotient divider, 2 placement stages, a
// 20-stage modulo divider and the output register.
// A stalled receiver freezes the whole pipeline once the one-entry skid
// behind the output register fills; nothing is dropped or repeated, and
// in_ready comes straight from a flop.
// Reset (rst_n low at a clock edge) empties the pipeline and loads the
// register defaults: no rotation, zoom 1.0, camera at origin, clamp mode,
// 1024 x 1024 map.
module perspective_floor_texel_mapper_top (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [pftm_pkg::COL_W-1:0] in_pixel_col,
  input  logic [pftm_pkg::ROW_W-1:0] in_pixel_row,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [pftm_pkg::DIM_W-1:0] out_texel_x,
  output logic [pftm_pkg::DIM_W-1:0] out_texel_y,
  output logic                       out_outside,
  input  logic                       cfg_we,
  input  logic [2:0]                 cfg_index,
  input  logic [23:0]                cfg_wdata
);
  import pftm_pkg::*;

  logic [15:0]      sine_r, cosine_r, zoom_r;
  logic [23:0]      cam_x_r, cam_z_r;
  logic             wrap_r;
  logic [MAP_W-1:0] map_w_r, map_h_r;
  logic [MAP_W-1:0] wsub, hsub;
  cfg_t             cfg;

  logic             en;
  front_t           fo;
  quot_t            qo;
  mod_stage_t       mo;

  logic [DIM_W-1:0] tpx, tpy;
  logic             oflag;
  logic             push;
  res_t             fin;

  logic             out_vld_r, out_vld_nxt;
  logic             skid_vld_r, skid_vld_nxt;
  res_t             out_r, out_nxt;
  res_t             skid_r, skid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sine_r   <= 16'h0000;
      cosine_r <= 16'h4000;
      zoom_r   <= 16'h0100;
      cam_x_r  <= '0;
      cam_z_r  <= '0;
      wrap_r   <= 1'b0;
      map_w_r  <= 13'd1024;
      map_h_r  <= 13'd1024;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SINE:       sine_r   <= cfg_wdata[15:0];
        REG_COSINE:     cosine_r <= cfg_wdata[15:0];
        REG_ZOOM:       zoom_r   <= cfg_wdata[15:0];
        REG_CAMERA_X:   cam_x_r  <= cfg_wdata;
        REG_CAMERA_Z:   cam_z_r  <= cfg_wdata;
        REG_WRAP_MODE:  wrap_r   <= cfg_wdata[0];
        REG_MAP_WIDTH:  map_w_r  <= cfg_wdata[MAP_W-1:0];
        REG_MAP_HEIGHT: map_h_r  <= cfg_wdata[MAP_W-1:0];
      endcase
    end
  end

  // map size saturated to 2..max, kept as size minus one
  always_comb begin
    wsub = map_w_r - 13'd1;
    hsub = map_h_r - 13'd1;
    cfg.sine   = sine_r;
    cfg.cosine = cosine_r;
    cfg.zoom   = zoom_r;
    cfg.cam_x  = cam_x_r;
    cfg.cam_z  = cam_z_r;
    cfg.wrap   = wrap_r;
    if (map_w_r < 13'd2) begin
      cfg.w_m1 = 12'd1;
    end else if (map_w_r > DIM_HI) begin
      cfg.w_m1 = '1;
    end else begin
      cfg.w_m1 = wsub[DIM_W-1:0];
    end
    if (map_h_r < 13'd2) begin
      cfg.h_m1 = 12'd1;
    end else if (map_h_r > DIM_HI) begin
      cfg.h_m1 = '1;
    end else begin
      cfg.h_m1 = hsub[DIM_W-1:0];
    end
  end

  assign en       = !skid_vld_r;
  assign in_ready = en;

  pftm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_vld    (in_valid),
    .pixel_col (in_pixel_col),
    .pixel_row (in_pixel_row),
    .cfg       (cfg),
    .fo        (fo)
  );

  pftm_qdiv u_qdiv (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .fi    (fo),
    .qo    (qo)
  );

  pftm_tile u_tile (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .qi    (qo),
    .cfg   (cfg),
    .mo    (mo)
  );

  // tiled: remainder rounded up by the half-texel bit; clamp: rounded position
  always_comb begin
    oflag = !wrap_r && mo.outside;
    if (wrap_r) begin
      tpx = mo.rem_x + {{(DIM_W-1){1'b0}}, mo.lo_x};
      tpy = mo.rem_y + {{(DIM_W-1){1'b0}}, mo.lo_y};
    end else begin
      tpx = mo.cx;
      tpy = mo.cy;
    end
    fin.outside = oflag;
    fin.texel_x = oflag ? '0 : tpx;
    fin.texel_y = oflag ? '0 : cfg.h_m1 - tpy;
  end

  assign push = en && mo.vld;

  always_comb begin
    out_vld_nxt  = out_vld_r;
    out_nxt      = out_r;
    skid_vld_nxt = skid_vld_r;
    skid_nxt     = skid_r;
    if (!out_vld_r || out_ready) begin
      if (skid_vld_r) begin
        out_vld_nxt  = 1'b1;
        out_nxt      = skid_r;
        skid_vld_nxt = 1'b0;
      end else begin
        out_vld_nxt = push;
        out_nxt     = fin;
      end
    end else if (push) begin
      skid_vld_nxt = 1'b1;
      skid_nxt     = fin;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid   = out_vld_r;
  assign out_texel_x = out_r.texel_x;
  assign out_texel_y = out_r.texel_y;
  assign out_outside = out_r.outside;

endmodule

// ----- rtl/core/pftm_front.sv -----
// front stages: pixel centering, rotation, zoom multiply and sign folding
module pftm_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_vld,
  input  logic [pftm_pkg::COL_W-1:0] pixel_col,
  input  logic [pftm_pkg::ROW_W-1:0] pixel_row,
  input  pftm_pkg::cfg_t             cfg,
  output pftm_pkg::front_t           fo
);
  import pftm_pkg::*;

  // stage a: centered coordinates and row distance
  logic signed [COL_W:0]   x_nxt;
  logic [Y_W-1:0]          y_nxt;
  logic signed [ROW_W:0]   z_raw;
  logic signed [ROW_W:0]   z_abs;
  logic                    zneg_nxt;
  logic [DEN_W-1:0]        den_nxt;

  logic                    vld_a_r;
  logic signed [COL_W:0]   x_a_r;
  logic [Y_W-1:0]          y_a_r;
  logic                    zneg_a_r;
  logic [DEN_W-1:0]        den_a_r;

  // stage b: rotation products
  logic signed [Y_W:0]     ys_a;
  logic signed [PROD_W-1:0] pxc_nxt, pys_nxt, pyc_nxt, pxs_nxt;
  logic                    vld_b_r;
  logic signed [PROD_W-1:0] pxc_b_r, pys_b_r, pyc_b_r, pxs_b_r;
  logic                    zneg_b_r;
  logic [DEN_W-1:0]        den_b_r;

  // stage c: rotated point
  logic signed [PROD_W-1:0] rx_nxt, ry_nxt;
  logic                    vld_c_r;
  logic signed [PROD_W-1:0] rx_c_r, ry_c_r;
  logic                    zneg_c_r;
  logic [DEN_W-1:0]        den_c_r;

  // stage d: zoomed numerators
  logic signed [16:0]      zoom_s;
  logic signed [NUM_W-1:0] nx_nxt, ny_nxt;
  logic                    vld_d_r;
  logic signed [NUM_W-1:0] nx_d_r, ny_d_r;
  logic                    zneg_d_r;
  logic [DEN_W-1:0]        den_d_r;

  // stage e: fold sign of the row distance, drop the q14 fraction
  logic signed [NUM_W-1:0] nfx, nfy;
  logic [QUOT_W:0]         shx, shy;
  front_t                  fo_nxt;
  front_t                  fo_r;

  always_comb begin
    x_nxt    = $signed({1'b0, pixel_col}) - X_CENTER;
    y_nxt    = {2'b00, pixel_row} + Y_OFFSET;
    z_raw    = $signed({1'b0, pixel_row}) - Z_CENTER;
    z_abs    = -z_raw;
    zneg_nxt = z_raw[ROW_W];
    if (z_raw == '0) begin
      den_nxt = 8'd1;
    end else if (zneg_nxt) begin
      den_nxt = z_abs[DEN_W-1:0];
    end else begin
      den_nxt = z_raw[DEN_W-1:0];
    end
  end

  always_comb begin
    ys_a    = $signed({1'b0, y_a_r});
    pxc_nxt = x_a_r * cfg.cosine;
    pys_nxt = ys_a * cfg.sine;
    pyc_nxt = ys_a * cfg.cosine;
    pxs_nxt = x_a_r * cfg.sine;
  end

  always_comb begin
    rx_nxt = pxc_b_r + pys_b_r;
    ry_nxt = pyc_b_r - pxs_b_r;
  end

  always_comb begin
    zoom_s = $signed({1'b0, cfg.zoom});
    nx_nxt = rx_c_r * zoom_s;
    ny_nxt = ry_c_r * zoom_s;
  end

  // floor(n / (z * 2^14)) == floor((+-n >>> 14) / |z|); negatives go through ~
  always_comb begin
    nfx        = zneg_d_r ? -nx_d_r : nx_d_r;
    nfy        = zneg_d_r ? -ny_d_r : ny_d_r;
    shx        = nfx[NUM_W-1:Q14_FRAC];
    shy        = nfy[NUM_W-1:Q14_FRAC];
    fo_nxt.vld = vld_d_r;
    fo_nxt.sx  = shx[QUOT_W];
    fo_nxt.sy  = shy[QUOT_W];
    fo_nxt.ux  = shx[QUOT_W] ? ~shx[QUOT_W-1:0] : shx[QUOT_W-1:0];
    fo_nxt.uy  = shy[QUOT_W] ? ~shy[QUOT_W-1:0] : shy[QUOT_W-1:0];
    fo_nxt.den = den_d_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r  <= 1'b0;
      vld_b_r  <= 1'b0;
      vld_c_r  <= 1'b0;
      vld_d_r  <= 1'b0;
      fo_r.vld <= 1'b0;
    end else if (en) begin
      vld_a_r  <= in_vld;
      vld_b_r  <= vld_a_r;
      vld_c_r  <= vld_b_r;
      vld_d_r  <= vld_c_r;
      fo_r     <= fo_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_a_r    <= x_nxt;
      y_a_r    <= y_nxt;
      zneg_a_r <= zneg_nxt;
      den_a_r  <= den_nxt;
      pxc_b_r  <= pxc_nxt;
      pys_b_r  <= pys_nxt;
      pyc_b_r  <= pyc_nxt;
      pxs_b_r  <= pxs_nxt;
      zneg_b_r <= zneg_a_r;
      den_b_r  <= den_a_r;
      rx_c_r   <= rx_nxt;
      ry_c_r   <= ry_nxt;
      zneg_c_r <= zneg_b_r;
      den_c_r  <= den_b_r;
      nx_d_r   <= nx_nxt;
      ny_d_r   <= ny_nxt;
      zneg_d_r <= zneg_c_r;
      den_d_r  <= den_c_r;
    end
  end

  assign fo = fo_r;

endmodule

// ----- rtl/core/pftm_qdiv.sv -----
// pipelined restoring divider, one quotient bit per stage, for both axes
module pftm_qdiv (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  pftm_pkg::front_t   fi,
  output pftm_pkg::quot_t    qo
);
  import pftm_pkg::*;

  div_stage_t st_in [QUOT_W];
  div_stage_t st_r  [QUOT_W];

  for (genvar k = 0; k < QUOT_W; k++) begin : g_stage
    localparam int B = QUOT_W - 1 - k;

    logic [DEN_W:0] tx, ty, dx, dy;
    logic           gex, gey;
    div_stage_t     nxt;

    if (k == 0) begin : g_first
      // partial remainders and quotients start at zero
      assign st_in[k] = {fi.vld, fi.ux, fi.uy, fi.sx, fi.sy, fi.den,
                         {DEN_W{1'b0}}, {DEN_W{1'b0}}, {QUOT_W{1'b0}}, {QUOT_W{1'b0}}};
    end else begin : g_next
      assign st_in[k] = st_r[k-1];
    end

    always_comb begin
      tx  = {st_in[k].rem_x, st_in[k].ux[B]};
      ty  = {st_in[k].rem_y, st_in[k].uy[B]};
      dx  = tx - {1'b0, st_in[k].den};
      dy  = ty - {1'b0, st_in[k].den};
      gex = tx >= {1'b0, st_in[k].den};
      gey = ty >= {1'b0, st_in[k].den};
      nxt = st_in[k];
      nxt.rem_x = gex ? dx[DEN_W-1:0] : tx[DEN_W-1:0];
      nxt.rem_y = gey ? dy[DEN_W-1:0] : ty[DEN_W-1:0];
      nxt.qx[B] = gex;
      nxt.qy[B] = gey;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        st_r[k].vld <= 1'b0;
      end else if (en) begin
        st_r[k] <= nxt;
      end
    end
  end

  always_comb begin
    qo.vld = st_r[QUOT_W-1].vld;
    qo.qx  = st_r[QUOT_W-1].qx;
    qo.qy  = st_r[QUOT_W-1].qy;
    qo.sx  = st_r[QUOT_W-1].sx;
    qo.sy  = st_r[QUOT_W-1].sy;
  end

endmodule

// ----- rtl/core/pftm_tile.sv -----
// camera offset, clamp test and pipelined modulo for tiled maps
module pftm_tile (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  pftm_pkg::quot_t       qi,
  input  pftm_pkg::cfg_t        cfg,
  output pftm_pkg::mod_stage_t  mo
);
  import pftm_pkg::*;

  // stage p1: floored quotient plus camera position
  logic [QUOT_W:0]         qsx, qsy;
  logic signed [POS_W-1:0] qxe, qye, camxe, camye;
  logic signed [POS_W-1:0] px_nxt, py_nxt;
  logic                    vld_p1_r;
  logic signed [POS_W-1:0] px_p1_r, py_p1_r;

  // stage p2: clamp test, rounding and split of the magnitude
  logic signed [POS_W-1:0] ax, ay;
  logic [HI_W-1:0]         rsx, rsy;
  logic                    outx, outy;
  mod_stage_t              p2_nxt;
  mod_stage_t              p2_r;

  mod_stage_t st_in [HI_W];
  mod_stage_t st_r  [HI_W];

  always_comb begin
    qsx    = qi.sx ? ~{1'b0, qi.qx} : {1'b0, qi.qx};
    qsy    = qi.sy ? ~{1'b0, qi.qy} : {1'b0, qi.qy};
    qxe    = POS_W'($signed(qsx));
    qye    = POS_W'($signed(qsy));
    camxe  = POS_W'(cfg.cam_x);
    camye  = POS_W'(cfg.cam_z);
    px_nxt = qxe + camxe;
    py_nxt = qye + camye;
  end

  always_comb begin
    ax   = px_p1_r[POS_W-1] ? -px_p1_r : px_p1_r;
    ay   = py_p1_r[POS_W-1] ? -py_p1_r : py_p1_r;
    rsx  = px_p1_r[HI_W-1:0] + 20'd128;
    rsy  = py_p1_r[HI_W-1:0] + 20'd128;
    outx = px_p1_r[POS_W-1] || (px_p1_r[POS_W-2:0] > {8'd0, cfg.w_m1, 8'd0});
    outy = py_p1_r[POS_W-1] || (py_p1_r[POS_W-2:0] > {8'd0, cfg.h_m1, 8'd0});
    p2_nxt.vld     = vld_p1_r;
    p2_nxt.hix     = ax[POS_W-2:8];
    p2_nxt.hiy     = ay[POS_W-2:8];
    p2_nxt.rem_x   = '0;
    p2_nxt.rem_y   = '0;
    p2_nxt.lo_x    = ax[7];
    p2_nxt.lo_y    = ay[7];
    p2_nxt.cx      = rsx[HI_W-1:8];
    p2_nxt.cy      = rsy[HI_W-1:8];
    p2_nxt.outside = outx || outy;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_p1_r <= 1'b0;
      p2_r.vld <= 1'b0;
    end else if (en) begin
      vld_p1_r <= qi.vld;
      p2_r     <= p2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px_p1_r <= px_nxt;
      py_p1_r <= py_nxt;
    end
  end

  // remainder of the texel part by (dim - 1), one bit per stage
  for (genvar k = 0; k < HI_W; k++) begin : g_stage
    localparam int B = HI_W - 1 - k;

    logic [DIM_W:0] tx, ty, dx, dy;
    logic           gex, gey;
    mod_stage_t     nxt;

    if (k == 0) begin : g_first
      assign st_in[k] = p2_r;
    end else begin : g_next
      assign st_in[k] = st_r[k-1];
    end

    always_comb begin
      tx  = {st_in[k].rem_x, st_in[k].hix[B]};
      ty  = {st_in[k].rem_y, st_in[k].hiy[B]};
      dx  = tx - {1'b0, cfg.w_m1};
      dy  = ty - {1'b0, cfg.h_m1};
      gex = tx >= {1'b0, cfg.w_m1};
      gey = ty >= {1'b0, cfg.h_m1};
      nxt = st_in[k];
      nxt.rem_x = gex ? dx[DIM_W-1:0] : tx[DIM_W-1:0];
      nxt.rem_y = gey ? dy[DIM_W-1:0] : ty[DIM_W-1:0];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        st_r[k].vld <= 1'b0;
      end else if (en) begin
        st_r[k] <= nxt;
      end
    end
  end

  assign mo = st_r[HI_W-1];

endmodule

// ----- verif/perspective_floor_texel_mapper_top_test.sv -----
// self-checking testbench for the perspective floor texel mapper top level
`timescale 1ns / 100ps

module perspective_floor_texel_mapper_top_test;
  import pftm_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int PHASE_ITEMS = 120;
  localparam int PHASES      = 12;
  localparam int HOLD_CYCLES = 300;

  typedef struct {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    res_t             want;
  } texel_entry_t;

  class texel_ledger;
    logic signed [15:0] sine_q14;
    logic signed [15:0] cosine_q14;
    logic [15:0]        zoom;
    logic signed [23:0] cam_x;
    logic signed [23:0] cam_z;
    logic               tiled;
    logic [MAP_W-1:0]   map_w;
    logic [MAP_W-1:0]   map_h;
    texel_entry_t       waiting[$];
    int                 requests;
    int                 results;
    int                 mismatches;
    int                 off_map;
    int                 tiled_requests;

    function new();
      sine_q14   = 16'sd0;
      cosine_q14 = 16'sd16384;
      zoom       = 16'd256;
      cam_x      = '0;
      cam_z      = '0;
      tiled      = 1'b0;
      map_w      = 13'd1024;
      map_h      = 13'd1024;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [23:0] word);
      case (idx)
        REG_SINE:       sine_q14   = word[15:0];
        REG_COSINE:     cosine_q14 = word[15:0];
        REG_ZOOM:       zoom       = word[15:0];
        REG_CAMERA_X:   cam_x      = word;
        REG_CAMERA_Z:   cam_z      = word;
        REG_WRAP_MODE:  tiled      = word[0];
        REG_MAP_WIDTH:  map_w      = word[MAP_W-1:0];
        REG_MAP_HEIGHT: map_h      = word[MAP_W-1:0];
        default: ;
      endcase
    endfunction

    function longint div_floor(longint num, longint den);
      longint q;
      q = num / den;
      if ((num % den) != 0 && ((num < 0) != (den < 0)))
        q -= 1;
      return q;
    endfunction

    function longint sat_dim(logic [MAP_W-1:0] dim);
      if (dim < 2)
        return 2;
      if (dim > MAP_DIM_MAX)
        return MAP_DIM_MAX;
      return longint'(dim);
    endfunction

    function longint wrap_texel(longint pos, longint dim);
      longint mag;
      longint period;
      mag    = (pos < 0) ? -pos : pos;
      period = (dim - 1) * 256;
      return ((mag % period) + 128) >>> 8;
    endfunction

    // floor point seen by one pixel under the current camera
    function res_t project_to_texel(logic [COL_W-1:0] col, logic [ROW_W-1:0] row);
      longint s, c, zm, w, h, x, y, z, rx, ry, den, px, py, tx, ty;
      res_t   r;
      s  = longint'(sine_q14);
      c  = longint'(cosine_q14);
      zm = longint'(zoom);
      w  = sat_dim(map_w);
      h  = sat_dim(map_h);
      x  = longint'(col) - SCREEN_WIDTH / 2;
      y  = longint'(row) + DEPTH_OFFSET;
      z  = longint'(row) - SCREEN_HEIGHT / 2;
      if (z == 0)
        z = 1;
      rx  = x * c + y * s;
      ry  = y * c - x * s;
      den = z * (longint'(1) << Q14_FRAC);
      px  = div_floor(rx * zm, den) + longint'(cam_x);
      py  = div_floor(ry * zm, den) + longint'(cam_z);
      tx  = 0;
      ty  = 0;
      r.outside = 1'b0;
      if (!tiled) begin
        if (px < 0 || px > (w - 1) * 256 || py < 0 || py > (h - 1) * 256) begin
          r.outside = 1'b1;
        end else begin
          tx = (px + 128) >>> 8;
          ty = (py + 128) >>> 8;
        end
      end else begin
        tx = wrap_texel(px, w);
        ty = wrap_texel(py, h);
      end
      if (!r.outside)
        ty = (h - 1) - ty;
      r.texel_x = tx[DIM_W-1:0];
      r.texel_y = ty[DIM_W-1:0];
      return r;
    endfunction

    function void note_request(logic [COL_W-1:0] col, logic [ROW_W-1:0] row);
      texel_entry_t e;
      e.col  = col;
      e.row  = row;
      e.want = project_to_texel(col, row);
      waiting.push_back(e);
      requests++;
      if (e.want.outside)
        off_map++;
      if (tiled)
        tiled_requests++;
    endfunction

    function void check_texel(logic [DIM_W-1:0] tx, logic [DIM_W-1:0] ty, logic outside);
      texel_entry_t e;
      results++;
      if (waiting.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result: x=%0d y=%0d outside=%0b", tx, ty, outside);
        mismatches++;
        return;
      end
      e = waiting.pop_front();
      if (tx !== e.want.texel_x || ty !== e.want.texel_y || outside !== e.want.outside) begin
        if (mismatches < 10)
          $display("mismatch col %0d row %0d: expected x=%0d y=%0d outside=%0b, %s",
                   e.col, e.row, e.want.texel_x, e.want.texel_y, e.want.outside,
                   $sformatf("got x=%0d y=%0d outside=%0b", tx, ty, outside));
        mismatches++;
      end
    endfunction

    function int pending();
      return waiting.size();
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [COL_W-1:0] in_pixel_col = '0;
  logic [ROW_W-1:0] in_pixel_row = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [DIM_W-1:0] out_texel_x;
  logic [DIM_W-1:0] out_texel_y;
  logic             out_outside;
  logic             cfg_we = 1'b0;
  logic [2:0]       cfg_index = '0;
  logic [23:0]      cfg_wdata = '0;

  texel_ledger ledger = new();
  int          cycles = 0;
  int          send_idle = 0;
  int          stall_pct = 0;
  logic        hold_off = 1'b0;
  int          settings_used = 1;

  perspective_floor_texel_mapper_top dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_pixel_col (in_pixel_col),
    .in_pixel_row (in_pixel_row),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_texel_x  (out_texel_x),
    .out_texel_y  (out_texel_y),
    .out_outside  (out_outside),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, ledger.pending());
      $display("simulation failed");
      $finish;
    end
  end

  // receiver: random stalls plus an optional long hold-off
  always @(posedge clk) begin
    out_ready <= !hold_off && ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready)
        ledger.note_request(in_pixel_col, in_pixel_row);
      if (out_valid && out_ready)
        ledger.check_texel(out_texel_x, out_texel_y, out_outside);
    end
  end

  task automatic send_request(input logic [COL_W-1:0] col, input logic [ROW_W-1:0] row);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_pixel_col <= col;
    in_pixel_row <= row;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic settle(input int extra);
    in_valid <= 1'b0;
    while (ledger.pending() != 0)
      @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [23:0] value, input int bits);
    logic [23:0] word;
    word = value;
    // junk above the register width must be ignored
    if (bits < 24 && $urandom_range(1))
      word = word | (24'($urandom) << bits);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= word;
    @(posedge clk);
    ledger.set_reg(idx, word);
  endtask

  task automatic load_setting(input int s, input int c, input int zm, input int cx,
                              input int cz, input int wr, input int w, input int h);
    write_reg(REG_SINE, 24'(s), 16);
    write_reg(REG_COSINE, 24'(c), 16);
    write_reg(REG_ZOOM, 24'(zm), 16);
    write_reg(REG_CAMERA_X, 24'(cx), 24);
    write_reg(REG_CAMERA_Z, 24'(cz), 24);
    write_reg(REG_WRAP_MODE, 24'(wr), 1);
    write_reg(REG_MAP_WIDTH, 24'(w), MAP_W);
    write_reg(REG_MAP_HEIGHT, 24'(h), MAP_W);
    cfg_we <= 1'b0;
    @(posedge clk);
    settings_used++;
  endtask

  function automatic int pick_dim();
    case ($urandom_range(7))
      0:       return $urandom_range(0, 1);
      1:       return $urandom_range(MAP_DIM_MAX + 1, 8191);
      2:       return MAP_DIM_MAX;
      3, 4:    return $urandom_range(2, 300);
      default: return $urandom_range(2, MAP_DIM_MAX);
    endcase
  endfunction

  function automatic int pick_trig();
    case ($urandom_range(7))
      0:       return 0;
      1:       return 16384;
      2:       return -16384;
      default: return int'($urandom_range(0, 32768)) - 16384;
    endcase
  endfunction

  function automatic int pick_camera(int dim);
    if ($urandom_range(9) < 7)
      return $urandom_range(0, dim * 256);
    return int'($urandom_range(0, 24'hFFFFFF)) - 8388608;
  endfunction

  task automatic random_setting(input int k);
    int zm, w, h;
    if (k == 0) begin
      load_setting(16384, 16384, 65535, 8388607, 8388607, 1, MAP_DIM_MAX, MAP_DIM_MAX);
    end else if (k == 1) begin
      load_setting(-16384, -16384, 1, -8388608, -8388608, 0, 2, 2);
    end else begin
      case ($urandom_range(9))
        0:       zm = 0;
        1:       zm = 65535;
        2:       zm = 1;
        default: zm = $urandom_range(16, 1024);
      endcase
      w = pick_dim();
      h = pick_dim();
      load_setting(pick_trig(), pick_trig(), zm, pick_camera(w), pick_camera(h),
                   $urandom_range(1), w, h);
    end
  endtask

  task automatic random_pixels(input int n);
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(3) != 0)
        col = COL_W'($urandom_range(0, SCREEN_WIDTH - 1));
      else
        col = COL_W'($urandom_range(0, 511));
      if ($urandom_range(3) != 0)
        row = ROW_W'($urandom_range(SCREEN_HEIGHT / 2, SCREEN_HEIGHT - 1));
      else
        row = ROW_W'($urandom_range(0, 255));
      send_request(col, row);
    end
  endtask

  // receiver holds off long enough that the pipeline backs up into in_ready
  task automatic hold_receiver(input int span);
    repeat (20) @(posedge clk);
    hold_off <= 1'b1;
    repeat (span) @(posedge clk);
    hold_off <= 1'b0;
  endtask

  // corner pixels: horizon row, above horizon, beyond screen, extreme columns
  int unsigned corner_col[23] = '{0, 319, 160, 319, 0, 200, 511, 511, 300, 170, 256, 255, 1, 320,
                                  0, 319, 511, 0,
                                  160, 0, 319, 250, 100};
  int unsigned corner_row[23] = '{120, 120, 120, 239, 239, 121, 255, 0, 119, 100, 128, 127, 1, 240,
                                  120, 239, 255, 0,
                                  200, 239, 121, 130, 180};

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < 14; i++)
      send_request(COL_W'(corner_col[i]), ROW_W'(corner_row[i]));
    settle(8);
    // zero zoom, saturated map sizes, tiled, camera at the extremes
    load_setting(-16384, 0, 0, -8388608, 8388607, 1, 0, 8191);
    for (int i = 14; i < 18; i++)
      send_request(COL_W'(corner_col[i]), ROW_W'(corner_row[i]));
    settle(8);
    // quarter turn over the middle of the largest map, clamped
    load_setting(16384, 0, 256, 2048 * 256, 2048 * 256, 0, MAP_DIM_MAX, MAP_DIM_MAX);
    for (int i = 18; i < 23; i++)
      send_request(COL_W'(corner_col[i]), ROW_W'(corner_row[i]));
    settle(8);

    for (int k = 0; k < PHASES; k++) begin
      random_setting(k);
      case (k % 4)
        0: begin send_idle = 0;  stall_pct <= 0;  end
        1: begin send_idle = 83; stall_pct <= 0;  end
        2: begin send_idle = 0;  stall_pct <= 83; end
        default: begin send_idle = 29; stall_pct <= 29; end
      endcase
      if (k == 4) begin
        fork
          random_pixels(PHASE_ITEMS);
          hold_receiver(HOLD_CYCLES);
        join
      end else begin
        random_pixels(PHASE_ITEMS);
      end
      settle(8);
    end

    stall_pct <= 0;
    settle(64);
    $display("%0d pixel requests under %0d register settings, %0d off-map, %0d tiled",
             ledger.requests, settings_used, ledger.off_map, ledger.tiled_requests);
    $display("%0d results checked, %0d mismatches, %0d cycles",
             ledger.results, ledger.mismatches, cycles);
    if (ledger.mismatches == 0 && ledger.pending() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
